### hw/rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and constants for the two-stack shared store.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int CNT_FIELD_W   = 5;

    // command codes
    localparam logic [1:0] CMD_PUSH_FIRST  = 2'd0;
    localparam logic [1:0] CMD_POP_FIRST   = 2'd1;
    localparam logic [1:0] CMD_PUSH_SECOND = 2'd2;
    localparam logic [1:0] CMD_POP_SECOND  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [WORD_W-1:0] push_value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic [1:0]               status;
        logic [CNT_FIELD_W-1:0]   first_count;
        logic [CNT_FIELD_W-1:0]   second_count;
    } rsp_item_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // item taken this cycle
        logic load_direct;  // result ready without a store read
        logic load_read;    // result takes the registered read data
    } dp_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_read;   // offered item is a pop of a non-empty stack
    } dp_stat_t;

endpackage

### hw/rtl/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: input handshake, store-read wait state, result valid flag.
// ----------------------------------------------------------------------------
module tss_ctrl
    import tss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg, state_next;
    logic valid_reg, valid_next;
    logic slot_free;

    assign slot_free = !valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && slot_free;
    assign rsp_valid = valid_reg;

    always_comb
    begin
        ctrl.accept      = cmd_valid && cmd_ready;
        ctrl.load_direct = ctrl.accept && !stat.needs_read;
        ctrl.load_read   = (state_reg == ST_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.accept && stat.needs_read)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.load_direct || ctrl.load_read)
            valid_next = 1'b1;
        else if (rsp_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

### hw/rtl/tss_datapath.sv
// ----------------------------------------------------------------------------
// tss_datapath
// Occupancy counters, shared entry store and result register.
// ----------------------------------------------------------------------------
module tss_datapath
    import tss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_item_t cmd_item,
    input  dp_ctrl_t  ctrl,
    output dp_stat_t  stat,
    output rsp_item_t rsp_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] store_mem [DEPTH];

    logic [CW-1:0]     lower_count_reg, lower_count_next;
    logic [CW-1:0]     upper_count_reg, upper_count_next;
    logic [WORD_W-1:0] rd_data_reg;
    rsp_item_t         rsp_reg, rsp_next;

    logic          is_pop, is_first, full, empty;
    logic [CW:0]   occupancy;
    logic [CW-1:0] lower_dec, upper_dec, sel_index;
    logic [AW-1:0] addr;
    logic          do_write, do_read;
    logic [CW+CNT_FIELD_W-1:0] first_wide, second_wide;

    assign is_pop    = (cmd_item.command == CMD_POP_FIRST)
                    || (cmd_item.command == CMD_POP_SECOND);
    assign is_first  = (cmd_item.command == CMD_PUSH_FIRST)
                    || (cmd_item.command == CMD_POP_FIRST);
    assign occupancy = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign full      = (occupancy >= (CW+1)'(DEPTH));
    assign empty     = is_first ? (lower_count_reg == '0) : (upper_count_reg == '0);
    assign stat.needs_read = is_pop && !empty;

    assign lower_dec = lower_count_reg - CW'(1);
    assign upper_dec = upper_count_reg - CW'(1);

    // first stack indexes from the bottom, second from the top
    always_comb
    begin
        case (cmd_item.command)
            CMD_PUSH_FIRST:  sel_index = lower_count_reg;
            CMD_POP_FIRST:   sel_index = lower_dec;
            CMD_PUSH_SECOND: sel_index = upper_count_reg;
            default:         sel_index = upper_dec;
        endcase
        if (is_first)
            addr = sel_index[AW-1:0];
        else
            addr = AW'(DEPTH - 1) - sel_index[AW-1:0];
    end

    assign do_write = ctrl.accept && !is_pop && !full;
    assign do_read  = ctrl.accept && stat.needs_read;

    always_comb
    begin
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        if (do_write)
        begin
            if (is_first)
                lower_count_next = lower_count_reg + CW'(1);
            else
                upper_count_next = upper_count_reg + CW'(1);
        end
        else if (do_read)
        begin
            if (is_first)
                lower_count_next = lower_dec;
            else
                upper_count_next = upper_dec;
        end
    end

    // low field bits of the counts, zero-extended when the counter is narrow
    assign first_wide  = {{CNT_FIELD_W{1'b0}}, lower_count_next};
    assign second_wide = {{CNT_FIELD_W{1'b0}}, upper_count_next};

    always_comb
    begin
        rsp_next = rsp_reg;
        if (ctrl.load_read)
        begin
            rsp_next.popped_value = rd_data_reg;
            rsp_next.status       = STAT_DONE;
            rsp_next.first_count  = first_wide[CNT_FIELD_W-1:0];
            rsp_next.second_count = second_wide[CNT_FIELD_W-1:0];
        end
        else if (ctrl.load_direct)
        begin
            rsp_next.popped_value = '0;
            if (is_pop)
                rsp_next.status = STAT_EMPTY;
            else if (full)
                rsp_next.status = STAT_FULL;
            else
                rsp_next.status = STAT_DONE;
            rsp_next.first_count  = first_wide[CNT_FIELD_W-1:0];
            rsp_next.second_count = second_wide[CNT_FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            store_mem[addr] <= cmd_item.push_value;
        if (do_read)
            rd_data_reg <= store_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end
        else
        begin
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_item = rsp_reg;

endmodule

### hw/rtl/two_stacks_shared_array_top.sv
// ----------------------------------------------------------------------------
// two_stacks_shared_array_top
// Two LIFO stacks in one store of DEPTH words, growing toward each other.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid/cmd_ready/cmd_item) takes one item per command:
//   push first, pop first, push second, pop second. Response channel
//   (rsp_valid/rsp_ready/rsp_item) returns exactly one item per command with
//   the popped word, a status (done, full, empty) and both occupancies.
//   Pushes, refused pushes and empty pops give their result in the cycle
//   after acceptance; a successful pop passes through the registered store
//   read and then the result register.
//   Pushes and empty pops run at one item per cycle while results are taken;
//   a successful pop holds off the next command until its store read is done.
//   The result register decouples the sides: a new command is accepted while
//   a result waits, as long as that result is taken in the same cycle or the
//   slot is empty. With rsp_ready low and a result pending, cmd_ready drops.
//   Reset clears both occupancy counters and the result valid flag; the
//   store itself is not cleared, as a pop only reads entries it pushed.
// ----------------------------------------------------------------------------
module two_stacks_shared_array_top
    import tss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd_item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp_item
);

    // command and status between sequencer and datapath
    dp_ctrl_t ctrl;
    dp_stat_t stat;

    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tss_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_item (cmd_item),
        .ctrl     (ctrl),
        .stat     (stat),
        .rsp_item (rsp_item)
    );

`ifndef SYNTH
    // a pop that needs the store is always followed by the read-data load
    a_pop_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.accept && stat.needs_read) |=> ctrl.load_read)
        else $error("store read not completed after pop");

    // no command is taken while the store read is outstanding
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_read |-> !cmd_ready)
        else $error("command accepted during store read");

    // refused or empty results never carry a word
    a_fail_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_item.status != STAT_DONE)) |-> (rsp_item.popped_value == '0))
        else $error("failed command returned a word");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.status == STAT_DONE || rsp_item.status == STAT_FULL
                       || rsp_item.status == STAT_EMPTY))
        else $error("undefined status code");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-stack shared store.
// A short scripted run hits empty pops, word extremes and both full refusals.
// 400 random commands follow, in push-heavy, pop-heavy and balanced stretches, so
// that the stacks meet and drain many times. Every response is checked against
// a local stack model. Both sides idle at random; once the response side holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
    import tss_pkg::*;

    localparam int DEPTH     = DEPTH_DEFAULT;
    localparam int N_RANDOM  = 400;
    localparam int HOLD_AT   = 150;   // response count where the long hold-off starts
    localparam int HOLD_LEN  = 60;    // cycles of that hold-off
    localparam int DRAIN_CYC = 20;    // settle time after the last response

    // one row of the scripted run; typed rows carry their own response
    typedef struct packed {
        logic [1:0]             command;
        logic [WORD_W-1:0]      value;
        logic                   typed_rsp;
        logic [WORD_W-1:0]      rsp_value;
        logic [1:0]             rsp_status;
        logic [CNT_FIELD_W-1:0] rsp_first;
        logic [CNT_FIELD_W-1:0] rsp_second;
    } script_row_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    cmd_item_t cmd_item;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp_item;

    // local copy of the stacks
    logic [WORD_W-1:0] shadow_mem [DEPTH];
    int unsigned       shadow_lo;
    int unsigned       shadow_hi;

    rsp_item_t   owed_rsp_q [$];   // responses the block still owes, oldest first
    script_row_t script_q [$];
    int          err_cnt;
    int          sent_cnt;
    int          rsp_cnt;

    two_stacks_shared_array_top #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d responses still owed", $time, owed_rsp_q.size());
        $display("TB_ERROR");
        $finish;
    end

    // Apply one command to the local stacks and return the response it earns.
    // Full is checked on the sum of both occupancies, so the stacks may meet
    // anywhere in the store.
    function automatic rsp_item_t apply_stack_cmd(cmd_item_t it);
        rsp_item_t r;
        logic      full;
        r    = '0;
        full = (shadow_lo + shadow_hi >= DEPTH);
        case (it.command)
            CMD_PUSH_FIRST:
            begin
                if (full)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_mem[shadow_lo] = it.push_value;
                    shadow_lo++;
                end
            end
            CMD_POP_FIRST:
            begin
                if (shadow_lo == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    shadow_lo--;
                    r.popped_value = shadow_mem[shadow_lo];
                end
            end
            CMD_PUSH_SECOND:
            begin
                if (full)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_mem[DEPTH - 1 - shadow_hi] = it.push_value;
                    shadow_hi++;
                end
            end
            default:
            begin
                if (shadow_hi == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    shadow_hi--;
                    r.popped_value = shadow_mem[DEPTH - 1 - shadow_hi];
                end
            end
        endcase
        r.first_count  = shadow_lo[CNT_FIELD_W-1:0];
        r.second_count = shadow_hi[CNT_FIELD_W-1:0];
        return r;
    endfunction

    // Idle cycles before the next item: none in calm stretches, else 0..11.
    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Random word, with the signed extremes and all-ones/zero mixed in.
    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Offer one item, hold it until taken, then log what it should return.
    // cmd_valid stays high straight across back-to-back items.
    task automatic send_item(input cmd_item_t it, input bit use_typed, input rsp_item_t typed);
        rsp_item_t predicted;
        int        gap;
        gap = draw_gap(((sent_cnt / 40) % 3) == 1);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do @(posedge clk); while (!cmd_ready);
        predicted = apply_stack_cmd(it);
        owed_rsp_q.push_back(use_typed ? typed : predicted);
        sent_cnt++;
    endtask

    // Response side: random stalls, calm stretches, and one long hold-off
    // while the sender keeps offering, so cmd_ready has to drop.
    initial
    begin
        rsp_item_t exp_rsp;
        int        stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(((rsp_cnt / 50) % 3) == 2);
            if (rsp_cnt == HOLD_AT)
                stall = HOLD_LEN;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            rsp_cnt++;
            if (owed_rsp_q.size() == 0)
            begin
                $display("%0t: response with none owed, actual %h", $time, rsp_item);
                err_cnt++;
            end
            else
            begin
                exp_rsp = owed_rsp_q.pop_front();
                if (rsp_item.popped_value !== exp_rsp.popped_value)
                begin
                    $display("%0t: popped_value expected %h actual %h",
                             $time, exp_rsp.popped_value, rsp_item.popped_value);
                    err_cnt++;
                end
                if (rsp_item.status !== exp_rsp.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_rsp.status, rsp_item.status);
                    err_cnt++;
                end
                if (rsp_item.first_count !== exp_rsp.first_count)
                begin
                    $display("%0t: first_count expected %0d actual %0d",
                             $time, exp_rsp.first_count, rsp_item.first_count);
                    err_cnt++;
                end
                if (rsp_item.second_count !== exp_rsp.second_count)
                begin
                    $display("%0t: second_count expected %0d actual %0d",
                             $time, exp_rsp.second_count, rsp_item.second_count);
                    err_cnt++;
                end
            end
        end
    end

    // Command side: reset, scripted rows, then the random stretch.
    initial
    begin
        script_row_t row;
        cmd_item_t   it;
        rsp_item_t   typed;
        int          mode;
        int          mode_left;
        int          pick;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        err_cnt   = 0;
        sent_cnt  = 0;
        rsp_cnt   = 0;
        shadow_lo = 0;
        shadow_hi = 0;
        foreach (shadow_mem[i])
            shadow_mem[i] = '0;

        // pops on empty stacks straight out of reset
        script_q.push_back('{CMD_POP_FIRST,   32'h0, 1'b1, 32'h0, STAT_EMPTY, 5'd0, 5'd0});
        script_q.push_back('{CMD_POP_SECOND,  32'h0, 1'b1, 32'h0, STAT_EMPTY, 5'd0, 5'd0});
        // signed extremes pushed and popped back on each stack
        script_q.push_back('{CMD_PUSH_FIRST,  32'h7FFF_FFFF, 1'b1, 32'h0, STAT_DONE, 5'd1, 5'd0});
        script_q.push_back('{CMD_PUSH_SECOND, 32'h8000_0000, 1'b1, 32'h0, STAT_DONE, 5'd1, 5'd1});
        script_q.push_back('{CMD_POP_FIRST,   32'h0, 1'b1, 32'h7FFF_FFFF, STAT_DONE, 5'd0, 5'd1});
        script_q.push_back('{CMD_POP_SECOND,  32'h0, 1'b1, 32'h8000_0000, STAT_DONE, 5'd0, 5'd0});
        script_q.push_back('{CMD_PUSH_FIRST,  32'hFFFF_FFFF, 1'b1, 32'h0, STAT_DONE, 5'd1, 5'd0});
        script_q.push_back('{CMD_PUSH_SECOND, 32'h0000_0000, 1'b1, 32'h0, STAT_DONE, 5'd1, 5'd1});
        // fill until the stacks meet in the middle
        for (int i = 0; i < 7; i++)
        begin
            script_q.push_back('{CMD_PUSH_FIRST,  32'h5555_5555 ^ i, 1'b0, 32'h0, STAT_DONE,
                                 5'd0, 5'd0});
            script_q.push_back('{CMD_PUSH_SECOND, 32'hAAAA_AAAA ^ i, 1'b0, 32'h0, STAT_DONE,
                                 5'd0, 5'd0});
        end
        // both pushes refused once full
        script_q.push_back('{CMD_PUSH_FIRST,  32'h1234_5678, 1'b1, 32'h0, STAT_FULL, 5'd8, 5'd8});
        script_q.push_back('{CMD_PUSH_SECOND, 32'h8765_4321, 1'b1, 32'h0, STAT_FULL, 5'd8, 5'd8});
        script_q.push_back('{CMD_POP_SECOND,  32'h0, 1'b0, 32'h0, STAT_DONE, 5'd0, 5'd0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_q[i])
        begin
            row                = script_q[i];
            it.command         = row.command;
            it.push_value      = row.value;
            typed.popped_value = row.rsp_value;
            typed.status       = row.rsp_status;
            typed.first_count  = row.rsp_first;
            typed.second_count = row.rsp_second;
            send_item(it, row.typed_rsp, typed);
        end

        // Random stretch. Modes: 0 push-heavy, 1 pop-heavy, 2 balanced,
        // 3 push-heavy on one stack only so one side takes the whole store.
        mode      = 0;
        mode_left = 0;
        typed     = '0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(15, 40);
            end
            mode_left--;
            pick = $urandom_range(0, 99);
            case (mode)
                0:       it.command = (pick < 85) ? {$urandom_range(0, 1) == 1, 1'b0}
                                                  : {$urandom_range(0, 1) == 1, 1'b1};
                1:       it.command = (pick < 85) ? {$urandom_range(0, 1) == 1, 1'b1}
                                                  : {$urandom_range(0, 1) == 1, 1'b0};
                2:       it.command = 2'($urandom_range(0, 3));
                default: it.command = (pick < 85) ? CMD_PUSH_FIRST : CMD_POP_SECOND;
            endcase
            it.push_value = draw_word();
            send_item(it, 1'b0, typed);
        end
        cmd_valid <= 1'b0;

        while (owed_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
